/* hw/rtl/wsdf_pkg.sv */
// Package for the websocket frame deframer.
// Holds the parse phase type, the queue entry type and the header constants.
// No dependencies.
`default_nettype none

package wsdf_pkg;

	typedef enum logic [2:0] {
		PH_B0   = 3'd0,
		PH_B1   = 3'd1,
		PH_EXT  = 3'd2,
		PH_KEY  = 3'd3,
		PH_DATA = 3'd4
	} wsdf_phase_t;

	localparam logic [6:0] LEN16_CODE = 7'd126;
	localparam logic [3:0] LEN16_BYTES = 4'd2;
	localparam logic [3:0] LEN64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES = 4'd4;

	localparam logic KIND_HDR = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	// one result on its way from the parser to the output stage
	typedef struct packed {
		logic        kind;
		logic        fin;
		logic [2:0]  rsv;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] length;
		logic [7:0]  raw;
		logic [7:0]  key;
		logic        last;
	} wsdf_entry_t;

endpackage

`default_nettype wire

/* hw/rtl/wsdf_front.sv */
// Frame header parser: takes one stream byte per cycle while accept is high and pushes results.
// Depends on wsdf_pkg.
`default_nettype none

module wsdf_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  wire [7:0]            in_byte,
	output logic                 push,
	output wsdf_pkg::wsdf_entry_t entry
);
	import wsdf_pkg::*;

	wsdf_phase_t phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [63:0] len_q, len_d;
	logic [63:0] rem_q, rem_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  midx_q, midx_d;
	logic        fin_q, fin_d;
	logic [2:0]  rsv_q, rsv_d;
	logic [3:0]  opc_q, opc_d;
	logic        masked_q, masked_d;
	logic [6:0]  code_q, code_d;

	logic        code_is_short;
	logic [3:0]  cnt_inc;
	logic        ext_done;
	logic        key_done;
	logic [63:0] len_shift;
	logic [63:0] rem_dec;
	logic        rem_zero;
	logic [7:0]  key_byte;
	logic        kind;
	logic        last;
	logic [7:0]  raw;
	logic [7:0]  kbyte;

	assign code_is_short = in_byte[6:0] < LEN16_CODE;
	assign cnt_inc   = cnt_q + 4'd1;
	assign ext_done  = cnt_inc >= ((code_q == LEN16_CODE) ? LEN16_BYTES : LEN64_BYTES);
	assign key_done  = cnt_inc >= KEY_BYTES;
	assign len_shift = {len_q[55:0], in_byte};
	assign rem_dec   = rem_q - 64'd1;
	// last payload byte when one byte is left; no compare behind the decrement
	assign rem_zero  = rem_q == 64'd1;

	always_comb begin
		unique case (midx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				PH_B1: begin
					if (!code_is_short)
						phase_d = PH_EXT;
					else if (in_byte[7])
						phase_d = PH_KEY;
					else if (in_byte[6:0] == 7'd0)
						phase_d = PH_B0;
					else
						phase_d = PH_DATA;
				end
				PH_EXT: begin
					if (ext_done) begin
						if (masked_q)
							phase_d = PH_KEY;
						else if (len_shift == 64'd0)
							phase_d = PH_B0;
						else
							phase_d = PH_DATA;
					end
				end
				PH_KEY: begin
					if (key_done)
						phase_d = (len_q == 64'd0) ? PH_B0 : PH_DATA;
				end
				PH_DATA: begin
					if (rem_zero)
						phase_d = PH_B0;
				end
				default: phase_d = PH_B1;
			endcase
		end
	end

	// datapath and result push
	always_comb begin
		cnt_d    = cnt_q;
		len_d    = len_q;
		rem_d    = rem_q;
		key_d    = key_q;
		midx_d   = midx_q;
		fin_d    = fin_q;
		rsv_d    = rsv_q;
		opc_d    = opc_q;
		masked_d = masked_q;
		code_d   = code_q;
		push     = 1'b0;
		kind     = KIND_HDR;
		last     = 1'b0;
		raw      = 8'd0;
		kbyte    = 8'd0;
		if (accept) begin
			unique case (phase_q)
				PH_B1: begin
					masked_d = in_byte[7];
					code_d   = in_byte[6:0];
					cnt_d    = 4'd0;
					len_d    = code_is_short ? {57'd0, in_byte[6:0]} : 64'd0;
					if (code_is_short && !in_byte[7]) begin
						key_d  = 32'd0;
						rem_d  = len_d;
						midx_d = 2'd0;
						push   = 1'b1;
						last   = len_d == 64'd0;
					end
				end
				PH_EXT: begin
					len_d = len_shift;
					cnt_d = ext_done ? 4'd0 : cnt_inc;
					if (ext_done && !masked_q) begin
						key_d  = 32'd0;
						rem_d  = len_shift;
						midx_d = 2'd0;
						push   = 1'b1;
						last   = len_shift == 64'd0;
					end
				end
				PH_KEY: begin
					key_d = {key_q[23:0], in_byte};
					cnt_d = key_done ? 4'd0 : cnt_inc;
					if (key_done) begin
						rem_d  = len_q;
						midx_d = 2'd0;
						push   = 1'b1;
						last   = len_q == 64'd0;
					end
				end
				PH_DATA: begin
					midx_d = midx_q + 2'd1;
					rem_d  = rem_dec;
					push   = 1'b1;
					kind   = KIND_DATA;
					last   = rem_zero;
					raw    = in_byte;
					kbyte  = masked_q ? key_byte : 8'd0;
				end
				default: begin
					fin_d = in_byte[7];
					rsv_d = in_byte[6:4];
					opc_d = in_byte[3:0];
				end
			endcase
		end
		entry.kind   = kind;
		entry.fin    = fin_d;
		entry.rsv    = rsv_d;
		entry.opcode = opc_d;
		entry.masked = masked_d;
		entry.length = len_d;
		entry.raw    = raw;
		entry.key    = kbyte;
		entry.last   = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_B0;
			cnt_q    <= 4'd0;
			len_q    <= 64'd0;
			rem_q    <= 64'd0;
			key_q    <= 32'd0;
			midx_q   <= 2'd0;
			fin_q    <= 1'b0;
			rsv_q    <= 3'd0;
			opc_q    <= 4'd0;
			masked_q <= 1'b0;
			code_q   <= 7'd0;
		end else begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			len_q    <= len_d;
			rem_q    <= rem_d;
			key_q    <= key_d;
			midx_q   <= midx_d;
			fin_q    <= fin_d;
			rsv_q    <= rsv_d;
			opc_q    <= opc_d;
			masked_q <= masked_d;
			code_q   <= code_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/wsdf_queue.sv */
// Short result queue between the parser and the output stage.
// Depends on wsdf_pkg.
`default_nettype none

module wsdf_queue #(
	parameter int Depth = 4
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wsdf_pkg::wsdf_entry_t push_entry,
	input  wire                   pop,
	output wsdf_pkg::wsdf_entry_t head,
	output logic                  full,
	output logic                  not_empty
);
	import wsdf_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	wsdf_entry_t         mem_q [Depth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;

	assign full      = count_q == CntW'(Depth);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth)) else $error("queue count beyond depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty queue");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !full) else $error("push into full queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

/* hw/rtl/wsdf_back.sv */
// Output stage: unmasks payload bytes and holds the result register.
// Depends on wsdf_pkg.
`default_nettype none

module wsdf_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wsdf_pkg::wsdf_entry_t head,
	input  wire                   not_empty,
	output logic                  pop,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic                  res_kind,
	output logic                  frame_fin,
	output logic [2:0]            frame_rsv,
	output logic [3:0]            frame_opcode,
	output logic                  frame_masked,
	output logic [63:0]           frame_length,
	output logic [7:0]            data_byte,
	output logic                  frame_last
);
	import wsdf_pkg::*;

	logic valid_q;

	assign pop       = not_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!valid_q || out_ready)
			valid_q <= not_empty;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_kind     <= head.kind;
			frame_fin    <= head.fin;
			frame_rsv    <= head.rsv;
			frame_opcode <= head.opcode;
			frame_masked <= head.masked;
			frame_length <= head.length;
			data_byte    <= head.raw ^ head.key;
			frame_last   <= head.last;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/websocket_frame_deframer_top.sv */
// Top level of the websocket frame deframer.
// Depends on wsdf_pkg, wsdf_front, wsdf_queue and wsdf_back.
//
// Usage:
//   Slave stream s_axis_* carries the received websocket byte stream, one byte
//   per word. Master stream m_axis_* returns one header word per frame once the
//   header (byte 0, byte 1, extended length, mask key) is complete, then one
//   word per payload byte, already unmasked. m_axis_tuser is the result kind
//   (0 header, 1 payload byte); m_axis_tlast marks the frame's final word, which
//   is the header word itself for a zero-length frame.
//   Throughput: one byte per clock while the queue is not full, with no gaps between frames.
//   A word on m_axis_tvalid passes through the queue write at the edge that accepts
//   the byte causing it, then through the output register.
//   The parser's per-byte update (64-bit length shift or count-down and compare
//   with one) sets the cycle time; the queue decouples it from the output side.
//   When the receiver stalls, the queue absorbs up to QueueDepth words plus the
//   output register; then s_axis_tready drops until words are taken again.
//   Reset clears the parser to expect byte 0 of a new frame, empties the queue
//   and drops m_axis_tvalid; no clearing pass is needed.
`default_nettype none

module websocket_frame_deframer_top #(
	parameter int QueueDepth = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// [0] frame_fin, [3:1] frame_rsv, [7:4] frame_opcode, [8] frame_masked,
	// [72:9] frame_length, [80:73] data_byte, [87:81] zero
	output logic [87:0] m_axis_tdata,
	output logic        m_axis_tuser,   // [0] res_kind
	output logic        m_axis_tlast    // frame_last
);
	import wsdf_pkg::*;

	logic        accept;
	logic        push;
	logic        pop;
	logic        full;
	logic        not_empty;
	wsdf_entry_t push_entry;
	wsdf_entry_t head;

	logic        frame_fin;
	logic [2:0]  frame_rsv;
	logic [3:0]  frame_opcode;
	logic        frame_masked;
	logic [63:0] frame_length;
	logic [7:0]  data_byte;

	// a byte may cause a result, so take it only with a free queue slot
	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid && !full;

	wsdf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (s_axis_tdata),
		.push    (push),
		.entry   (push_entry)
	);

	wsdf_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (full),
		.not_empty  (not_empty)
	);

	wsdf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.not_empty    (not_empty),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.res_kind     (m_axis_tuser),
		.frame_fin    (frame_fin),
		.frame_rsv    (frame_rsv),
		.frame_opcode (frame_opcode),
		.frame_masked (frame_masked),
		.frame_length (frame_length),
		.data_byte    (data_byte),
		.frame_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, data_byte, frame_length, frame_masked,
		frame_opcode, frame_rsv, frame_fin};

endmodule

`default_nettype wire
